/* design/lsht_pkg.sv */
package lsht_pkg;

   localparam int SETS_DEFAULT = 256;
   localparam int WAYS_DEFAULT = 4;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [3:0] KEY_BYTES_RESET = 4'd4;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
      rotl32 = (x << r) | (x >> (32 - r));
   endfunction

endpackage

/* design/lru_set_assoc_hash_table.sv */
// Set-associative key/value table with least-recently-used replacement.
// Request channel (req_valid/req_ready) carries command, key and data; the
// response channel (rsp_valid/rsp_ready) returns status and value, one
// response per request, in order. csr_valid/csr_ready writes key_bytes
// (0 acts as 1, above 8 acts as 8); write it only while the block is idle.
// After the request transfer the block steps through hash mixing (MIX1,
// MIX2), reduction of the hash to a set index by reciprocal multiplication
// (DIV1, DIV2), the synchronous set read (READ), and a compare of the ways
// with set write-back while the response register and rsp_valid load (MOD).
// A request is taken one at a time; the next one enters once the block is
// idle and the response register is free or being taken, so no request
// enters before the last one's response is loaded. The set memory holds
// valid, recency, key and value of all ways of one set in one word, read
// and written once per request. After reset a clearing pass writes every
// set empty, one set per cycle, during which no request is accepted.
// A stalled response is held in its register until rsp_ready is seen.
module lru_set_assoc_hash_table #(
   parameter int SETS = lsht_pkg::SETS_DEFAULT,
   parameter int WAYS = lsht_pkg::WAYS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_key,
   input  logic [63:0] req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [63:0] rsp_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_key_bytes
);
   import lsht_pkg::*;

   localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WIDX = (WAYS > 1) ? $clog2(WAYS) : 1;
   // floor(2^(32+SW) / SETS): quotient estimate is exact or one low
   localparam logic [63:0] RECIP = (64'd1 << (32 + SW)) / 64'(SETS);

   typedef struct packed {
      logic            valid;
      logic [RW-1:0]   rank;
      logic [63:0]     key;
      logic [63:0]     value;
   } way_type;
   typedef way_type [WAYS-1:0] set_type;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MIX1  = 3'd2;
   localparam logic [2:0] ST_MIX2  = 3'd3;
   localparam logic [2:0] ST_DIV1  = 3'd4;
   localparam logic [2:0] ST_DIV2  = 3'd5;
   localparam logic [2:0] ST_READ  = 3'd6;
   localparam logic [2:0] ST_MOD   = 3'd7;

   set_type mem [SETS];
   set_type rd_ff;

   logic [2:0]    state_ff, state_in;
   logic [SW-1:0] clr_ff;
   logic [3:0]    kb_ff;
   logic [1:0]    cmd_ff;
   logic [63:0]   key_ff, data_ff, mask_ff;
   logic [31:0]   a_ff, b_ff, c_ff, a_in, b_in, c_in;
   logic [31:0]   q_ff;
   logic [SW-1:0] set_ff;
   logic          rsp_valid_ff;
   logic          rsp_status_ff;
   logic [63:0]   rsp_value_ff;

   // effective length and mask from the register
   logic [3:0]  n_len;
   logic [63:0] n_mask;
   always_comb begin
      n_len = (kb_ff == 4'd0) ? 4'd1 : ((kb_ff > 4'd8) ? 4'd8 : kb_ff);
      n_mask = (n_len == 4'd8) ? '1 : ((64'd1 << {n_len, 3'b000}) - 64'd1);
   end

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

   // lookup3 final mix, split over the MIX1 and MIX2 states; c_ff ends with the hash
   logic [31:0] init, ia, ib, ic;
   logic [31:0] a1, b1, c1, a2, b2, c2;
   always_comb begin
      init = 32'hdeadbeef + {28'd0, n_len};
      ia = init + key_ff[31:0];
      ib = init + key_ff[63:32];
      ic = init;
      c1 = (ic ^ ib) - rotl32(ib, 14);
      a1 = (ia ^ c1) - rotl32(c1, 11);
      b1 = (ib ^ a1) - rotl32(a1, 25);
      c2 = (c_ff ^ b_ff) - rotl32(b_ff, 16);
      a2 = (a_ff ^ c2) - rotl32(c2, 4);
      b2 = (b_ff ^ a2) - rotl32(a2, 14);
      a_in = (state_ff == ST_MIX1) ? a1 : a2;
      b_in = (state_ff == ST_MIX1) ? b1 : b2;
      c_in = (state_ff == ST_MIX1) ? c1 : ((c2 ^ b2) - rotl32(b2, 24));
   end

   // hash modulo SETS: quotient estimate, then remainder with one correction
   logic [95:0] div_prod;
   logic [47:0] div_back;
   logic [31:0] div_rem;
   logic [31:0] set_rem;
   always_comb begin
      div_prod = 96'(c_ff) * 96'(RECIP);
      div_back = 48'(q_ff) * 48'(SETS);
      div_rem = c_ff - div_back[31:0];
      set_rem = (div_rem >= 32'(SETS)) ? div_rem - 32'(SETS) : div_rem;
   end

   // set update
   set_type nset;
   logic    hit;
   logic [WIDX-1:0] hit_w;
   logic [RW-1:0]   hit_r;
   logic [63:0]     hit_val;
   logic            full;
   logic            found_slot;
   logic [WIDX-1:0] slot_w;
   always_comb begin
      nset = rd_ff;
      hit = 1'b0;
      hit_w = '0;
      hit_r = '0;
      hit_val = '0;
      full = 1'b1;
      found_slot = 1'b0;
      slot_w = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (rd_ff[w].valid && ((rd_ff[w].key & mask_ff) == key_ff)) begin
            if (!hit || rd_ff[w].rank < hit_r) begin
               hit = 1'b1;
               hit_w = WIDX'(w);
               hit_r = rd_ff[w].rank;
               hit_val = rd_ff[w].value;
            end
         end
         if (!rd_ff[w].valid) full = 1'b0;
      end
      case (cmd_ff)
         CMD_LOOKUP: begin
            if (hit) begin
               for (int w = 0; w < WAYS; w++)
                  if (rd_ff[w].valid && rd_ff[w].rank < hit_r)
                     nset[w].rank = rd_ff[w].rank + RW'(1);
               nset[hit_w].rank = '0;
            end
         end
         CMD_ADD: begin
            if (full) begin
               for (int w = WAYS - 1; w >= 0; w--)
                  if (rd_ff[w].rank == RW'(WAYS - 1)) begin
                     found_slot = 1'b1;
                     slot_w = WIDX'(w);
                  end
            end
            for (int w = 0; w < WAYS; w++) begin
               if (!(full && found_slot && slot_w == WIDX'(w)) && rd_ff[w].valid)
                  nset[w].rank = rd_ff[w].rank + RW'(1);
            end
            if (!full) begin
               for (int w = WAYS - 1; w >= 0; w--)
                  if (!rd_ff[w].valid) slot_w = WIDX'(w);
               found_slot = 1'b1;
            end
            if (found_slot) begin
               nset[slot_w].valid = 1'b1;
               nset[slot_w].rank  = '0;
               nset[slot_w].key   = key_ff;
               nset[slot_w].value = data_ff;
            end
         end
         CMD_DELETE: begin
            if (hit) begin
               for (int w = 0; w < WAYS; w++)
                  if (rd_ff[w].valid && rd_ff[w].rank > hit_r)
                     nset[w].rank = rd_ff[w].rank - RW'(1);
               nset[hit_w].valid = 1'b0;
               nset[hit_w].rank  = '0;
            end
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == SW'(SETS - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid && req_ready) state_in = ST_MIX1;
         ST_MIX1:  state_in = ST_MIX2;
         ST_MIX2:  state_in = ST_DIV1;
         ST_DIV1:  state_in = ST_DIV2;
         ST_DIV2:  state_in = ST_READ;
         ST_READ:  state_in = ST_MOD;
         ST_MOD:   state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         kb_ff <= KEY_BYTES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + SW'(1);
         if (csr_valid) kb_ff <= csr_key_bytes;
         if (state_ff == ST_MOD) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // request capture, hash and response payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff  <= req_command;
         key_ff  <= req_key & n_mask;
         mask_ff <= n_mask;
         data_ff <= req_data;
      end
      if (state_ff == ST_MIX1 || state_ff == ST_MIX2) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
      end
      if (state_ff == ST_DIV1) q_ff <= div_prod[32 + SW +: 32];
      if (state_ff == ST_DIV2) set_ff <= SW'(set_rem);
      if (state_ff == ST_MOD) begin
         rsp_status_ff <= (cmd_ff == CMD_ADD) ? 1'b0 :
                          ((cmd_ff == CMD_LOOKUP || cmd_ff == CMD_DELETE) ? !hit : 1'b1);
         rsp_value_ff  <= (cmd_ff == CMD_LOOKUP && hit) ? hit_val : 64'd0;
      end
   end

   // set memory: one read and one write port
   set_type clr_word;
   always_comb begin
      clr_word = '0;
   end
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) rd_ff <= mem[set_ff];
      if (state_ff == ST_CLEAR) mem[clr_ff] <= clr_word;
      else if (state_ff == ST_MOD) mem[set_ff] <= nset;
   end

endmodule

/* bench/lsht_checker.sv */
`timescale 1ns / 100ps

// Watches the request, response and csr channels, predicts every response
// and compares it with what the table returns.
module lsht_checker
   import lsht_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_key,
   input  logic [63:0] req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_status,
   input  logic [63:0] rsp_value,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_key_bytes,
   output int          errors,
   output int          pending
);

   localparam int NSETS = SETS_DEFAULT;
   localparam int NWAYS = WAYS_DEFAULT;
   localparam int NENT  = NSETS * NWAYS;

   typedef struct packed {
      logic        status;
      logic [63:0] value;
   } answer_type;

   // shadow copy of the table
   logic        slot_used [NENT];
   logic [63:0] slot_key  [NENT];
   logic [63:0] slot_val  [NENT];
   int          slot_age  [NENT];
   logic [3:0]  klen_reg;
   answer_type  answers_due [$];

   function automatic logic [31:0] rol(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   // lookup3 final mix over at most 8 key bytes
   function automatic logic [31:0] key_hash(input logic [63:0] k, input int n);
      logic [31:0] a, b, c;
      a = 32'hdeadbeef + n;
      b = a;
      c = a;
      a += k[31:0];
      b += k[63:32];
      c ^= b; c -= rol(b, 14);
      a ^= c; a -= rol(c, 11);
      b ^= a; b -= rol(a, 25);
      c ^= b; c -= rol(b, 16);
      a ^= c; a -= rol(c, 4);
      b ^= a; b -= rol(a, 14);
      c ^= b; c -= rol(b, 24);
      return c;
   endfunction

   // most recent matching entry of a set, or -1
   function automatic int newest_match(input int base, input logic [63:0] k,
                                       input logic [63:0] m);
      int hit;
      hit = -1;
      for (int w = 0; w < NWAYS; w++) begin
         if (slot_used[base+w] && ((slot_key[base+w] & m) == k)) begin
            if (hit < 0 || slot_age[base+w] < slot_age[hit]) hit = base + w;
         end
      end
      return hit;
   endfunction

   // applies one request to the shadow table and returns its response
   function automatic answer_type table_op(input logic [1:0] cmd, input logic [63:0] key,
                                           input logic [63:0] data);
      answer_type ans;
      int n, base, hit, r, cnt, free;
      logic [63:0] m, k;
      n = (klen_reg == 0) ? 1 : (klen_reg > 8) ? 8 : int'(klen_reg);
      m = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 1);
      k = key & m;
      base = int'(key_hash(k, n) % NSETS) * NWAYS;
      ans.status = 1'b1;
      ans.value = '0;
      case (cmd)
         CMD_LOOKUP: begin
            hit = newest_match(base, k, m);
            if (hit >= 0) begin
               r = slot_age[hit];
               for (int w = 0; w < NWAYS; w++)
                  if (slot_used[base+w] && slot_age[base+w] < r) slot_age[base+w]++;
               slot_age[hit] = 0;
               ans.status = 1'b0;
               ans.value = slot_val[hit];
            end
         end
         CMD_ADD: begin
            cnt = 0;
            for (int w = 0; w < NWAYS; w++) if (slot_used[base+w]) cnt++;
            // full set: drop the least recent entry
            if (cnt >= NWAYS) begin
               for (int w = 0; w < NWAYS; w++) begin
                  if (slot_used[base+w] && slot_age[base+w] == NWAYS - 1) begin
                     slot_used[base+w] = 1'b0;
                     break;
                  end
               end
            end
            free = -1;
            for (int w = 0; w < NWAYS; w++) begin
               if (slot_used[base+w]) slot_age[base+w]++;
               else if (free < 0) free = base + w;
            end
            if (free >= 0) begin
               slot_used[free] = 1'b1;
               slot_key[free] = k;
               slot_val[free] = data;
               slot_age[free] = 0;
            end
            ans.status = 1'b0;
         end
         CMD_DELETE: begin
            hit = newest_match(base, k, m);
            if (hit >= 0) begin
               r = slot_age[hit];
               slot_used[hit] = 1'b0;
               slot_age[hit] = 0;
               for (int w = 0; w < NWAYS; w++)
                  if (slot_used[base+w] && slot_age[base+w] > r) slot_age[base+w]--;
               ans.status = 1'b0;
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         klen_reg <= KEY_BYTES_RESET;
         for (int i = 0; i < NENT; i++) begin
            slot_used[i] = 1'b0;
            slot_age[i] = 0;
         end
         answers_due.delete();
         errors <= 0;
         pending <= 0;
      end else begin
         // csr transfer
         if (csr_valid && csr_ready) klen_reg <= csr_key_bytes;
         // request transfer
         if (req_valid && req_ready) answers_due.push_back(table_op(req_command, req_key,
                                                                     req_data));
         // response transfer
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected response status=%0b value=%h", $time,
                        rsp_status, rsp_value);
               errors <= errors + 1;
            end else begin
               want = answers_due.pop_front();
               if (want.status !== rsp_status || want.value !== rsp_value) begin
                  $display("%0t: expected status=%0b value=%h, actual status=%0b value=%h",
                           $time, want.status, want.value, rsp_status, rsp_value);
                  errors <= errors + 1;
               end
            end
         end
         pending <= answers_due.size();
      end
   end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
   import lsht_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_LOOKUP;
   logic [63:0] req_key = '0;
   logic [63:0] req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [63:0] rsp_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_key_bytes = '0;
   int          errors, pending;
   bit          steady = 1'b0;
   int          quiet_cycles = 0;
   logic [63:0] key_pool [16];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   lru_set_assoc_hash_table DUT (.*);

   lsht_checker monitor (.*);

   // response side stalls, none while steady
   always @(posedge clock) rsp_ready <= steady || ($urandom_range(99) >= 16);

   // watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("lru_set_assoc_hash_table: mismatch");
         $finish;
      end
   end

   // one request transfer; valid stays high if the next item follows at once
   task automatic send_req(input logic [1:0] cmd, input logic [63:0] key,
                           input logic [63:0] data);
      if (!steady && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_key <= key;
      req_data <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_key_bytes(input logic [3:0] nbytes);
      drain();
      csr_valid <= 1'b1;
      csr_key_bytes <= nbytes;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // mostly pooled keys so hits, duplicates and evictions happen
   task automatic random_req();
      logic [1:0]  cmd;
      logic [63:0] key;
      int pick;
      pick = $urandom_range(99);
      cmd = (pick < 40) ? CMD_LOOKUP : (pick < 75) ? CMD_ADD :
            (pick < 95) ? CMD_DELETE : CMD_NONE;
      pick = $urandom_range(99);
      key = key_pool[$urandom_range(15)];
      if (pick < 15) key = rand64();
      else if (pick < 40) key = key ^ (rand64() & {32'hffffffff, 32'h0});
      send_req(cmd, key, rand64());
   endtask

   initial begin
      logic [3:0] klen_plan [8] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd6, 4'd2, 4'd9, 4'd4};
      foreach (key_pool[i]) key_pool[i] = rand64();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: misses on empty table, extremes, all commands
      send_req(CMD_LOOKUP, '0, '0);
      send_req(CMD_DELETE, '1, '0);
      send_req(CMD_ADD, '0, '1);
      send_req(CMD_ADD, '1, '0);
      send_req(CMD_LOOKUP, '0, '0);
      send_req(CMD_LOOKUP, 64'hffffffff, '0);
      send_req(CMD_NONE, '1, '1);
      send_req(CMD_DELETE, '0, '0);
      send_req(CMD_LOOKUP, '0, '0);
      // same key five times: full set evicts the oldest, newest copy wins
      for (int i = 0; i < 5; i++) send_req(CMD_ADD, 64'h1234, 64'(i + 100));
      send_req(CMD_LOOKUP, 64'h1234, '0);
      send_req(CMD_DELETE, 64'h1234, '0);
      send_req(CMD_LOOKUP, 64'h1234, '0);
      // bytes above key_bytes are ignored
      send_req(CMD_LOOKUP, 64'haaaa_5555_ffff_ffff, '0);
      send_req(CMD_ADD, 64'h5555_aaaa_0000_0000, 64'h5555_aaaa_5555_aaaa);
      send_req(CMD_LOOKUP, 64'hffff_ffff_0000_0000, '0);

      // random phases over several key lengths
      foreach (klen_plan[p]) begin
         write_key_bytes(klen_plan[p]);
         steady = (p == 3);
         for (int i = 0; i < 60; i++) begin
            random_req();
            if (p == 5 && i == 30) drain();
         end
      end
      steady = 1'b0;
      drain();

      if (errors == 0 && pending == 0) begin
         $display("lru_set_assoc_hash_table: match");
      end else begin
         $display("lru_set_assoc_hash_table: mismatch");
      end
      $finish;
   end

endmodule
